>>> hw/rtl/als_pkg.sv
package als_pkg;

    // Strip limits and field widths
    localparam int MAX_PIXELS  = 256;
    localparam int PIX_W       = 9;
    localparam int TIME_W      = 12;
    localparam int WORD_W      = 24;
    localparam int BIT_IDX_W   = 5;
    localparam int CHAN_W      = 8;
    localparam int COLOUR_W    = 16;
    localparam int POWER_W     = 16;

    // Configuration port
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COLOUR   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXELS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_HI   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 3'd5;

    // Register reset values
    localparam logic [PIX_W-1:0]  PIXELS_RST  = 9'd8;
    localparam logic [TIME_W-1:0] ZERO_HI_RST = 12'd22;
    localparam logic [TIME_W-1:0] ONE_HI_RST  = 12'd45;
    localparam logic [TIME_W-1:0] PERIOD_RST  = 12'd80;

    // Power estimate: n*60*b/255 = 4*n*b/17, taken as (n*b*RECIP_17) >> RECIP_SHIFT
    localparam int NB_W        = PIX_W + CHAN_W;
    localparam int RECIP_W     = 18;
    localparam logic [RECIP_W-1:0] RECIP_17 = 18'd246724;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = RECIP_SHIFT + POWER_W;

    // Stream widths
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 24;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour;
        logic [CHAN_W-1:0]   brightness;
        logic [PIX_W-1:0]    pixel_count;
        logic [TIME_W-1:0]   zero_high;
        logic [TIME_W-1:0]   one_high;
        logic [TIME_W-1:0]   bit_period;
    } cfg_t;

    // Beat between the bit timer and the output stage
    typedef struct packed {
        logic            line;
        logic            busy;
        logic [NB_W-1:0] nb;
    } st1_t;

    // floor(v*b/255): 16-bit product, then reciprocal with one correction
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] v,
                                                     input logic [CHAN_W-1:0] b);
        logic [15:0] p;
        logic [16:0] s;
        p = 16'(v) * 16'(b);
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

    // RGB565 to scaled GRB888 by bit replication
    function automatic logic [WORD_W-1:0] make_grb(input logic [COLOUR_W-1:0] colour,
                                                   input logic [CHAN_W-1:0]   b);
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        logic [CHAN_W-1:0] r8;
        logic [CHAN_W-1:0] g8;
        logic [CHAN_W-1:0] b8;
        r5 = colour[15:11];
        g6 = colour[10:5];
        b5 = colour[4:0];
        r8 = {r5, r5[4:2]};
        g8 = {g6, g6[5:4]};
        b8 = {b5, b5[4:2]};
        return {scale_chan(g8, b), scale_chan(r8, b), scale_chan(b8, b)};
    endfunction

    // Clamp the pixel count to 1..MAX_PIXELS
    function automatic logic [PIX_W-1:0] eff_pixels(input logic [PIX_W-1:0] pc);
        logic [PIX_W-1:0] n;
        n = pc;
        if (pc == '0) begin
            n = PIX_W'(1);
        end else if (pc > PIX_W'(MAX_PIXELS)) begin
            n = PIX_W'(MAX_PIXELS);
        end
        return n;
    endfunction

endpackage

>>> hw/rtl/als_cfg_regs.sv
module als_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [als_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [als_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output als_pkg::cfg_t                   cfg,
    output logic                            cfg_touch
);

    als_pkg::cfg_t cfg_reg;
    als_pkg::cfg_t cfg_next;
    logic          hit;

    // Decode the write and update one register
    always_comb begin
        cfg_next = cfg_reg;
        hit      = 1'b0;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                als_pkg::REG_COLOUR: begin
                    cfg_next.colour = cfg_wdata;
                    hit = 1'b1;
                end
                als_pkg::REG_BRIGHT: begin
                    cfg_next.brightness = cfg_wdata[als_pkg::CHAN_W-1:0];
                    hit = 1'b1;
                end
                als_pkg::REG_PIXELS: begin
                    cfg_next.pixel_count = cfg_wdata[als_pkg::PIX_W-1:0];
                    hit = 1'b1;
                end
                als_pkg::REG_ZERO_HI: begin
                    cfg_next.zero_high = cfg_wdata[als_pkg::TIME_W-1:0];
                    hit = 1'b1;
                end
                als_pkg::REG_ONE_HI: begin
                    cfg_next.one_high = cfg_wdata[als_pkg::TIME_W-1:0];
                    hit = 1'b1;
                end
                als_pkg::REG_PERIOD: begin
                    cfg_next.bit_period = cfg_wdata[als_pkg::TIME_W-1:0];
                    hit = 1'b1;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.colour      <= '0;
            cfg_reg.brightness  <= '0;
            cfg_reg.pixel_count <= als_pkg::PIXELS_RST;
            cfg_reg.zero_high   <= als_pkg::ZERO_HI_RST;
            cfg_reg.one_high    <= als_pkg::ONE_HI_RST;
            cfg_reg.bit_period  <= als_pkg::PERIOD_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg       = cfg_reg;
    assign cfg_touch = hit;

endmodule

>>> hw/rtl/als_bit_timer.sv
module als_bit_timer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           accept,
    input  logic           advance,
    input  logic           refresh,
    input  als_pkg::cfg_t  cfg,
    input  logic           cfg_touch,
    output als_pkg::st1_t  st1,
    output logic           st1_valid
);

    localparam int SLOT_EXT_W = als_pkg::TIME_W + 1;
    localparam int PIX_EXT_W  = als_pkg::PIX_W + 1;

    logic                            dirty_reg, dirty_next;
    logic                            sending_reg, sending_next;
    logic [als_pkg::WORD_W-1:0]      grb_reg, grb_next;
    logic [als_pkg::TIME_W-1:0]      slot_reg, slot_next;
    logic [als_pkg::BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [als_pkg::PIX_W-1:0]       pix_reg, pix_next;
    als_pkg::st1_t                   st1_reg, st1_next;
    logic                            st1_valid_reg;

    logic                            start;
    logic                            act;
    logic [als_pkg::WORD_W-1:0]      word;
    logic [als_pkg::TIME_W-1:0]      slot;
    logic [als_pkg::BIT_IDX_W-1:0]   bidx;
    logic [als_pkg::PIX_W-1:0]       pidx;
    logic [als_pkg::PIX_W-1:0]       eff;
    logic                            bit_val;
    logic [als_pkg::TIME_W-1:0]      hi;
    logic                            slot_end;
    logic                            bit_end;
    logic                            pix_end;

    // Current bit slot, with a refresh that starts a frame taking effect this tick
    always_comb begin
        start    = refresh && !sending_reg && dirty_reg;
        act      = sending_reg || start;
        word     = start ? als_pkg::make_grb(cfg.colour, cfg.brightness) : grb_reg;
        slot     = start ? '0 : slot_reg;
        bidx     = start ? '0 : bit_reg;
        pidx     = start ? '0 : pix_reg;
        eff      = als_pkg::eff_pixels(cfg.pixel_count);
        bit_val  = word[als_pkg::BIT_IDX_W'(als_pkg::WORD_W - 1) - bidx];
        hi       = bit_val ? cfg.one_high : cfg.zero_high;
        slot_end = (SLOT_EXT_W'(slot) + SLOT_EXT_W'(1)) >= SLOT_EXT_W'(cfg.bit_period);
        bit_end  = bidx == als_pkg::BIT_IDX_W'(als_pkg::WORD_W - 1);
        pix_end  = (PIX_EXT_W'(pidx) + PIX_EXT_W'(1)) >= PIX_EXT_W'(eff);

        st1_next.line = act && (slot < hi);
        st1_next.busy = act;
        st1_next.nb   = als_pkg::NB_W'(eff) * als_pkg::NB_W'(cfg.brightness);
    end

    // Advance slot, bit and pixel counters on each accepted beat
    always_comb begin
        dirty_next   = dirty_reg;
        sending_next = sending_reg;
        grb_next     = grb_reg;
        slot_next    = slot_reg;
        bit_next     = bit_reg;
        pix_next     = pix_reg;
        if (accept) begin
            if (start) begin
                dirty_next = 1'b0;
            end
            if (act) begin
                grb_next     = word;
                sending_next = 1'b1;
                slot_next    = slot;
                bit_next     = bidx;
                pix_next     = pidx;
                if (slot_end) begin
                    slot_next = '0;
                    if (bit_end) begin
                        bit_next = '0;
                        if (pix_end) begin
                            pix_next     = '0;
                            sending_next = 1'b0;
                        end else begin
                            pix_next = pidx + als_pkg::PIX_W'(1);
                        end
                    end else begin
                        bit_next = bidx + als_pkg::BIT_IDX_W'(1);
                    end
                end else begin
                    slot_next = slot + als_pkg::TIME_W'(1);
                end
            end
        end
        // Any register write marks the strip for a resend
        if (cfg_touch) begin
            dirty_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_reg     <= 1'b1;
            sending_reg   <= 1'b0;
            grb_reg       <= '0;
            slot_reg      <= '0;
            bit_reg       <= '0;
            pix_reg       <= '0;
            st1_valid_reg <= 1'b0;
        end else begin
            dirty_reg   <= dirty_next;
            sending_reg <= sending_next;
            grb_reg     <= grb_next;
            slot_reg    <= slot_next;
            bit_reg     <= bit_next;
            pix_reg     <= pix_next;
            if (advance) begin
                st1_valid_reg <= accept;
            end
        end
    end

    // Hold the stage payload until the output stage takes it
    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= st1_next;
        end
    end

    assign st1       = st1_reg;
    assign st1_valid = st1_valid_reg;

endmodule

>>> hw/rtl/als_out_stage.sv
module als_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  als_pkg::st1_t                  st1,
    input  logic                           st1_valid,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [als_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                           advance
);

    localparam int PAD_W = als_pkg::M_DATA_W - als_pkg::POWER_W - 2;

    logic                           m_valid_reg;
    logic [als_pkg::M_DATA_W-1:0]   m_data_reg;
    logic [als_pkg::M_DATA_W-1:0]   m_data_next;
    logic [als_pkg::PROD_W-1:0]     prod;
    logic [als_pkg::POWER_W-1:0]    power;

    // Power = floor(4*n*b/17) by reciprocal; its maximum stays far below saturation
    always_comb begin
        prod        = als_pkg::PROD_W'(st1.nb) * als_pkg::PROD_W'(als_pkg::RECIP_17);
        power       = prod[als_pkg::RECIP_SHIFT +: als_pkg::POWER_W];
        m_data_next = {PAD_W'(0), power, st1.busy, st1.line};
    end

    assign advance = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= st1_valid;
        end
    end

    // Load a new beat whenever the register is free or drained
    always_ff @(posedge aclk) begin
        if (advance && st1_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> hw/rtl/addressable_led_serializer.sv
// Channel | Ports                          | Beat contents (low bit first)
// ------- | ------------------------------ | ------------------------------------------
// in      | s_tvalid s_tready s_tdata[7:0] | refresh [0], zeros [7:1]
// out     | m_tvalid m_tready m_tdata[23:0]| line_level [0], busy_res [1],
//         |                                | power_mw [17:2], zeros [23:18]
// cfg     | cfg_wr_en cfg_addr cfg_wdata   | register index, write data
//
// One beat in and one beat out per cycle while m_tready is high; a beat passes from input to output
// through the bit timer stage, then the power estimate and output register.
// Reset (aresetn low, synchronous) restores the register defaults and sets the dirty mark.
// A stall on m_tready holds both stages and drops s_tready in the same cycle.
// Register writes take effect for beats accepted after the write edge.
module addressable_led_serializer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [als_pkg::S_DATA_W-1:0]    s_tdata,   // [0] refresh
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [als_pkg::M_DATA_W-1:0]    m_tdata,   // [0] line_level, [1] busy_res,
                                                       // [17:2] power_mw
    input  logic                            cfg_wr_en,
    input  logic [als_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [als_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    als_pkg::cfg_t  cfg;
    logic           cfg_touch;
    als_pkg::st1_t  st1;
    logic           st1_valid;
    logic           advance;
    logic           accept;

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    als_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .cfg_touch (cfg_touch)
    );

    als_bit_timer u_timer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .advance   (advance),
        .refresh   (s_tdata[0]),
        .cfg       (cfg),
        .cfg_touch (cfg_touch),
        .st1       (st1),
        .st1_valid (st1_valid)
    );

    als_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .st1       (st1),
        .st1_valid (st1_valid),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .advance   (advance)
    );

endmodule

>>> tb/sv/led_serializer_checker.sv
module led_serializer_checker
    import als_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,      // [0] refresh
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,      // [0] line_level, [1] busy_res, [17:2] power_mw
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    fail_count,
    output int                    pending_beats
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               line_level;
        logic               busy;
        logic [POWER_W-1:0] power_mw;
    } strip_beat_t;

    // Shadow copy of the register file
    logic [COLOUR_W-1:0] colour_q;
    logic [CHAN_W-1:0]   bright_q;
    logic [PIX_W-1:0]    pixels_q;
    logic [TIME_W-1:0]   zero_hi_q;
    logic [TIME_W-1:0]   one_hi_q;
    logic [TIME_W-1:0]   period_q;

    // Shadow copy of the transmitter state
    logic                dirty_q;
    logic                sending_q;
    logic [WORD_W-1:0]   grb_q;
    int                  slot_q;
    int                  bit_q;
    int                  pixel_q;

    strip_beat_t         expected_beats[$];
    int                  result_count;

    initial begin
        fail_count    = 0;
        pending_beats = 0;
        result_count  = 0;
    end

    // Pixel count as the strip sees it: at least one, at most the strip limit
    function automatic int pixels_in_use();
        if (pixels_q == '0) begin
            return 1;
        end
        if (int'(pixels_q) > MAX_PIXELS) begin
            return MAX_PIXELS;
        end
        return int'(pixels_q);
    endfunction

    function automatic int dim_channel(input int level);
        return (level * int'(bright_q)) / 255;
    endfunction

    // Widen 5/6/5 to 8 bits by repeating the top bits, then apply brightness
    function automatic logic [WORD_W-1:0] dimmed_grb();
        int r5;
        int g6;
        int b5;
        int r8;
        int g8;
        int b8;
        r5 = int'(colour_q[15:11]);
        g6 = int'(colour_q[10:5]);
        b5 = int'(colour_q[4:0]);
        r8 = ((r5 << 3) | (r5 >> 2)) & 'hFF;
        g8 = ((g6 << 2) | (g6 >> 4)) & 'hFF;
        b8 = ((b5 << 3) | (b5 >> 2)) & 'hFF;
        return {CHAN_W'(dim_channel(g8)), CHAN_W'(dim_channel(r8)), CHAN_W'(dim_channel(b8))};
    endfunction

    function automatic logic [POWER_W-1:0] strip_power_mw();
        int mw;
        mw = pixels_in_use() * 60 * int'(bright_q) / 255;
        if (mw > 65535) begin
            mw = 65535;
        end
        return POWER_W'(mw);
    endfunction

    task automatic reset_shadow();
        colour_q  = '0;
        bright_q  = '0;
        pixels_q  = PIXELS_RST;
        zero_hi_q = ZERO_HI_RST;
        one_hi_q  = ONE_HI_RST;
        period_q  = PERIOD_RST;
        dirty_q   = 1'b1;
        sending_q = 1'b0;
        grb_q     = '0;
        slot_q    = 0;
        bit_q     = 0;
        pixel_q   = 0;
        expected_beats.delete();
    endtask

    // Any known register write marks the strip dirty; unknown indexes do nothing
    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic known;
        known = 1'b1;
        case (idx)
            REG_COLOUR:  colour_q  = data[COLOUR_W-1:0];
            REG_BRIGHT:  bright_q  = data[CHAN_W-1:0];
            REG_PIXELS:  pixels_q  = data[PIX_W-1:0];
            REG_ZERO_HI: zero_hi_q = data[TIME_W-1:0];
            REG_ONE_HI:  one_hi_q  = data[TIME_W-1:0];
            REG_PERIOD:  period_q  = data[TIME_W-1:0];
            default:     known     = 1'b0;
        endcase
        if (known) begin
            dirty_q = 1'b1;
        end
    endtask

    // Advance the strip by one tick and produce the line state for it
    task automatic tick_strip(input logic refresh, output strip_beat_t beat);
        logic tx_bit;
        int   high_len;
        int   sel;
        if (!sending_q && refresh && dirty_q) begin
            dirty_q   = 1'b0;
            grb_q     = dimmed_grb();
            sending_q = 1'b1;
            slot_q    = 0;
            bit_q     = 0;
            pixel_q   = 0;
        end
        beat = '0;
        if (sending_q) begin
            sel             = (bit_q < 24) ? bit_q : 23;
            tx_bit          = grb_q[23 - sel];
            high_len        = tx_bit ? int'(one_hi_q) : int'(zero_hi_q);
            beat.line_level = (slot_q < high_len);
            beat.busy       = 1'b1;
            if (slot_q + 1 >= int'(period_q)) begin
                slot_q = 0;
                bit_q++;
                if (bit_q >= 24) begin
                    bit_q = 0;
                    pixel_q++;
                    if (pixel_q >= pixels_in_use()) begin
                        pixel_q   = 0;
                        sending_q = 1'b0;
                    end
                end
            end else begin
                slot_q = (slot_q + 1) & 'hFFF;
            end
        end
        beat.power_mw = strip_power_mw();
    endtask

    // Predict on each input beat, compare each output beat, then take register writes
    always @(posedge aclk) begin
        strip_beat_t want;
        strip_beat_t got;
        if (!aresetn) begin
            reset_shadow();
        end else begin
            if (s_tvalid && s_tready) begin
                tick_strip(s_tdata[0], want);
                expected_beats.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.line_level = m_tdata[0];
                got.busy       = m_tdata[1];
                got.power_mw   = m_tdata[17:2];
                if (expected_beats.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("[%0t] result %0d arrived with nothing expected: line=%0b busy=%0b power=%0d",
                                 $time, result_count, got.line_level, got.busy, got.power_mw);
                    end
                end else begin
                    want = expected_beats.pop_front();
                    if (got.line_level !== want.line_level || got.busy !== want.busy ||
                        got.power_mw !== want.power_mw) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("[%0t] result %0d mismatch: expected line=%0b busy=%0b power=%0d, got line=%0b busy=%0b power=%0d",
                                     $time, result_count, want.line_level, want.busy, want.power_mw,
                                     got.line_level, got.busy, got.power_mw);
                        end
                    end
                end
                result_count++;
            end
            if (cfg_wr_en) begin
                apply_write(cfg_addr, cfg_wdata);
            end
        end
        pending_beats = expected_beats.size();
    end

endmodule

>>> tb/sv/addressable_led_serializer_tb.sv
module addressable_led_serializer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import als_pkg::*;

    localparam int RANDOM_TICKS = 1300;
    localparam int SETTLE_CYCLES = 4;
    // Indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;    // [0] refresh, [7:1] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;    // [0] line_level, [1] busy_res, [17:2] power_mw
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int fail_count;
    int pending_beats;
    int burst_left;
    logic [15:0] stall_clock;

    addressable_led_serializer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    led_serializer_checker u_strip_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending_beats (pending_beats)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: rotate through always ready, light stalls, heavy stalls and a fixed pattern
    initial stall_clock = '0;
    always @(posedge aclk) begin
        stall_clock <= stall_clock + 16'd1;
        case (stall_clock[8:7])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_clock[2:0] != 3'd0) && (stall_clock[2:0] != 3'd5);
        endcase
    end

    // Send one tick beat; open a fresh burst after a random gap when the last one ran out
    task automatic send_tick(input logic refresh);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W-1){1'b0}}, refresh};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // Hold the sender until every predicted beat has come back, then let the pipe settle;
    // sample the pending count on the falling edge, after the checker has updated it
    task automatic drain_strip();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(negedge aclk);
        while (pending_beats != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge aclk);
    endtask

    // Pick a new strip setup, mostly short slots and few pixels
    task automatic retune_strip();
        int pick;
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 7);
            write_reg(REG_COLOUR, (pick == 0) ? 0 : (pick == 1) ? 'hFFFF : $urandom_range(0, 65535));
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 3);
            write_reg(REG_BRIGHT, (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(0, 255));
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 15);
            write_reg(REG_PIXELS, (pick == 0) ? 0 : (pick == 1) ? $urandom_range(257, 511) :
                                  (pick == 2) ? MAX_PIXELS : $urandom_range(1, 3));
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 7);
            write_reg(REG_ZERO_HI, (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(1, 7));
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 7);
            write_reg(REG_ONE_HI, (pick == 0) ? 0 : (pick == 1) ? 4095 : $urandom_range(1, 7));
        end
        if ($urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, 31);
            write_reg(REG_PERIOD, (pick == 0) ? 4095 : (pick == 1) ? 0 :
                                  (pick == 2) ? 1 : $urandom_range(2, 6));
        end
        if ($urandom_range(0, 7) == 0) begin
            write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_A : REG_SPARE_B,
                      $urandom_range(0, 65535));
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase_len;
        int style;
        logic refresh;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        aresetn    = 1'b0;
        burst_left = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Dirty after reset, but no refresh: the line must stay idle
        send_tick(1'b0);
        send_tick(1'b0);
        drain_strip();

        // Full red and blue, full brightness, one-tick slots, pixel count zero,
        // zero bits never high, one bits high the whole slot
        write_reg(REG_COLOUR, 'hF81F);
        write_reg(REG_BRIGHT, 255);
        write_reg(REG_PIXELS, 0);
        write_reg(REG_ZERO_HI, 0);
        write_reg(REG_ONE_HI, 4095);
        write_reg(REG_PERIOD, 0);
        write_reg(REG_SPARE_B, 'h1234);
        cfg_wr_en <= 1'b0;
        // Refresh on every tick: start, refresh while busy, then refresh while clean
        repeat (26) send_tick(1'b1);

        // Random phases, each opened on a drained pipe, mostly after a register update
        sent = 0;
        while (sent < RANDOM_TICKS) begin
            drain_strip();
            if ($urandom_range(0, 7) != 0) begin
                retune_strip();
            end
            phase_len = $urandom_range(15, 90);
            style     = $urandom_range(0, 3);
            for (int i = 0; i < phase_len; i++) begin
                case (style)
                    0:       refresh = 1'b1;
                    1:       refresh = ($urandom_range(0, 7) == 0);
                    2:       refresh = (i == 0);
                    default: refresh = $urandom_range(0, 1);
                endcase
                send_tick(refresh);
                sent++;
            end
        end

        drain_strip();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending_beats == 0) begin
            $display("addressable_led_serializer_tb: PASS");
        end else begin
            $display("addressable_led_serializer_tb: FAIL");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #20_000_000;
        $display("addressable_led_serializer_tb: FAIL");
        $finish;
    end

endmodule
